/* rtl/core/bpa_pkg.sv */
// Package with constants, codes and shared types of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

   // Geometry of the page store.
   localparam int NUM_PAGES   = 1024;
   localparam int PAGE_W      = 10;
   localparam int BYTE_W      = 7;
   localparam int NUM_BYTES   = NUM_PAGES / 8;
   localparam int REF_BIT     = 4;
   localparam int SHARE_BIT   = 8;
   localparam int MAX_RUN     = 64;
   localparam int COUNT_W     = 7;
   localparam int FLAGS_W     = 16;
   localparam int REFS_W      = 16;
   localparam int FREE_W      = 11;
   localparam int LINKS_W     = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [FLAGS_W-1:0] MARK_MASK =
      FLAGS_W'((1 << REF_BIT) | (1 << SHARE_BIT));
   localparam logic [REFS_W-1:0]  REFS_MAX   = '1;
   localparam logic [FREE_W-1:0]  IN_USE_MAX = '1;
   localparam logic [LINKS_W-1:0] LINKS_MAX  = '1;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_TAKE    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_RUN   = 2'd1;
   localparam logic [1:0] STATUS_OUT_ZONE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_FIRST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_LAST  = 2'd1;

   // Outcome of the take or release rule on one page.
   typedef struct packed {
      logic [FLAGS_W-1:0] attr;
      logic [REFS_W-1:0]  refs;
      logic               set_used;
      logic               clr_used;
      logic               in_use_inc;
      logic               in_use_dec;
      logic               links_inc;
      logic               links_dec;
   } page_upd_type;

endpackage

`default_nettype wire

/* rtl/core/bpa_if.sv */
// Channel interfaces of the bitmap page allocator.
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [PAGE_W-1:0]   page_index;
   logic [COUNT_W-1:0]  page_count;
   logic [FLAGS_W-1:0]  attr_flags;
   modport source(output valid, cmd, page_index, page_count, attr_flags, input ready);
   modport sink(input valid, cmd, page_index, page_count, attr_flags, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [PAGE_W-1:0]   first_page;
   logic [FREE_W-1:0]   free_pages;
   modport source(output valid, status, first_page, free_pages, input ready);
   modport sink(input valid, status, first_page, free_pages, output ready);
endinterface

interface bpa_csr_if import bpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [PAGE_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bpa_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* rtl/core/bpa_page_rule.sv */
// Take and release rules applied to one page entry.
`default_nettype none

module bpa_page_rule import bpa_pkg::*; (
   input  wire logic               release_op,
   input  wire logic [FLAGS_W-1:0] attr,
   input  wire logic [REFS_W-1:0]  refs,
   input  wire logic [FLAGS_W-1:0] flags,
   output page_upd_type            upd
);

   logic [REFS_W-1:0] refs_up;
   logic [REFS_W-1:0] refs_dn;

   assign refs_up = (refs != REFS_MAX) ? refs + REFS_W'(1) : refs;
   assign refs_dn = (refs != '0) ? refs - REFS_W'(1) : refs;

   always_comb begin
      upd = '0;
      upd.attr = attr;
      upd.refs = refs;
      if (!release_op) begin
         // Take: first use, shared add-reference, or attribute merge.
         if (attr == '0) begin
            upd.attr       = flags;
            upd.refs       = refs_up;
            upd.set_used   = 1'b1;
            upd.in_use_inc = 1'b1;
            upd.links_inc  = 1'b1;
         end else if (((attr | flags) & MARK_MASK) != '0) begin
            upd.attr      = attr | flags;
            upd.refs      = refs_up;
            upd.links_inc = 1'b1;
         end else begin
            upd.attr     = attr | flags;
            upd.set_used = 1'b1;
         end
      end else if (attr != '0) begin
         // Release: drop a reference of a marked page, else free it.
         if ((attr & MARK_MASK) != '0) begin
            upd.refs      = refs_dn;
            upd.links_dec = 1'b1;
            if (refs_dn == '0) begin
               upd.attr       = '0;
               upd.in_use_dec = 1'b1;
            end
         end else begin
            upd.attr       = '0;
            upd.refs       = '0;
            upd.clr_used   = 1'b1;
            upd.in_use_dec = 1'b1;
            upd.links_dec  = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bitmap_page_allocator.sv */
// Top level of the bitmap page allocator: control sequencer and state memories.
//
// Channel   Direction  Payload
// req_chan  in         cmd, page_index, page_count, attr_flags
// rsp_chan  out        status, first_page, free_pages
// csr_chan  in         index (0 zone_first_page, 1 zone_last_page), data
//
// Take and release of a page inside the zone step through accept, page read,
// page write and result. An out-of-zone page, a rejected allocate or an
// unknown command steps through accept and result. Allocate steps through
// accept, a bitmap byte read and an evaluation of its eight bits for each byte
// scanned, a page read and a page write for each page of the run, and result.
// After reset a clearing pass writes all 1024 page entries, one a cycle, and
// no item is accepted during it. A waiting result does not block acceptance;
// a finished item waits only while the previous result is still not taken.
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   bpa_req_if.sink    req_chan,
   bpa_rsp_if.source  rsp_chan,
   bpa_csr_if.sink    csr_chan
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EVAL, S_PG_RD, S_PG_WR, S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_W-1:0]    zf_ff, zf_in, zl_ff, zl_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   logic [1:0]           status_ff, status_in;
   logic [PAGE_W-1:0]    first_ff, first_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [COUNT_W-1:0]   left_ff, left_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [COUNT_W-1:0]   run_ff, run_in;
   logic [PAGE_W-1:0]    clr_ff, clr_in;
   logic [FREE_W-1:0]    in_use_ff, in_use_in;
   logic [LINKS_W-1:0]   links_ff, links_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [FREE_W-1:0]    rsp_free_ff, rsp_free_in;

   // Memory ports.
   logic                      bm_we;
   logic [BYTE_W-1:0]         bm_waddr, bm_raddr;
   logic [7:0]                bm_wdata, bm_rdata;
   logic                      pm_we;
   logic [PAGE_W-1:0]         pm_waddr;
   logic [FLAGS_W+REFS_W-1:0] pm_wdata, pm_rdata;

   page_upd_type              upd;

   logic                 has_zone;
   logic [FREE_W-1:0]    zone_size;
   logic [FREE_W-1:0]    free_now;
   logic                 accept;
   logic                 scan_found;
   logic [COUNT_W-1:0]   scan_run;
   logic [PAGE_W-1:0]    scan_end;
   logic [PAGE_W-1:0]    scan_page;
   logic                 last_page;

   bpa_ram #(.WIDTH(8), .DEPTH(NUM_BYTES)) u_bitmap (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .raddr(bm_raddr), .rdata(bm_rdata)
   );

   bpa_ram #(.WIDTH(FLAGS_W + REFS_W), .DEPTH(NUM_PAGES)) u_pages (
      .clock(clock), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
      .raddr(page_ff), .rdata(pm_rdata)
   );

   bpa_page_rule u_rule (
      .release_op(cmd_ff == CMD_RELEASE),
      .attr(pm_rdata[FLAGS_W+REFS_W-1:REFS_W]),
      .refs(pm_rdata[REFS_W-1:0]),
      .flags(flags_ff),
      .upd(upd)
   );

   // Zone size and free page count from the current state.
   assign has_zone  = (zf_ff <= zl_ff);
   assign zone_size = has_zone ? ({1'b0, zl_ff} - {1'b0, zf_ff} + FREE_W'(1)) : '0;
   assign free_now  = (in_use_ff >= zone_size) ? '0 : zone_size - in_use_ff;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.first_page = rsp_first_ff;
   assign rsp_chan.free_pages = rsp_free_ff;

   // Memory address and data selection.
   assign bm_raddr = (state_ff == S_SCAN_RD) ? byte_ff : page_ff[PAGE_W-1:3];
   assign bm_waddr = (state_ff == S_CLEAR) ? clr_ff[BYTE_W-1:0] : page_ff[PAGE_W-1:3];
   assign pm_waddr = (state_ff == S_CLEAR) ? clr_ff : page_ff;
   assign pm_we    = (state_ff == S_CLEAR) || (state_ff == S_PG_WR);
   assign bm_we    = (state_ff == S_CLEAR) || (state_ff == S_PG_WR);
   assign pm_wdata = (state_ff == S_CLEAR) ? '0 : {upd.attr, upd.refs};

   always_comb begin
      bm_wdata = '0;
      if (state_ff != S_CLEAR) begin
         bm_wdata = bm_rdata;
         if (upd.set_used) begin
            bm_wdata[page_ff[2:0]] = 1'b1;
         end else if (upd.clr_used) begin
            bm_wdata[page_ff[2:0]] = 1'b0;
         end
      end
   end

   // Run search over the eight pages of one bitmap byte.
   always_comb begin
      scan_found = 1'b0;
      scan_run   = run_ff;
      scan_end   = '0;
      for (int j = 0; j < 8; j++) begin
         scan_page = {byte_ff, 3'(j)};
         if (!scan_found && scan_page >= zf_ff && scan_page <= zl_ff) begin
            scan_run = bm_rdata[j] ? '0 : scan_run + COUNT_W'(1);
            if (scan_run == cnt_ff) begin
               scan_found = 1'b1;
               scan_end   = scan_page;
            end
         end
      end
   end

   assign last_page = (left_ff == COUNT_W'(1));

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      zf_in         = zf_ff;
      zl_in         = zl_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      flags_in      = flags_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      page_in       = page_ff;
      left_in       = left_ff;
      byte_in       = byte_ff;
      run_in        = run_ff;
      clr_in        = clr_ff;
      in_use_in     = in_use_ff;
      links_in      = links_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_free_in   = rsp_free_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_ZONE_FIRST: zf_in = csr_chan.data;
            CSR_ZONE_LAST:  zl_in = csr_chan.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + PAGE_W'(1);
            if (clr_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_chan.cmd;
               cnt_in   = req_chan.page_count;
               flags_in = req_chan.attr_flags;
               first_in = req_chan.page_index;
               page_in  = req_chan.page_index;
               left_in  = COUNT_W'(1);
               status_in = STATUS_OK;
               unique case (req_chan.cmd)
                  CMD_ALLOC: begin
                     first_in = '0;
                     if (has_zone && req_chan.page_count != '0 &&
                         req_chan.page_count <= COUNT_W'(MAX_RUN) &&
                         free_now >= FREE_W'(req_chan.page_count)) begin
                        byte_in  = zf_ff[PAGE_W-1:3];
                        run_in   = '0;
                        state_in = S_SCAN_RD;
                     end else begin
                        status_in = STATUS_NO_RUN;
                        state_in  = S_RESP;
                     end
                  end
                  CMD_TAKE, CMD_RELEASE: begin
                     if (!has_zone || req_chan.page_index < zf_ff ||
                         req_chan.page_index > zl_ff) begin
                        status_in = STATUS_OUT_ZONE;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_PG_RD;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN_RD: state_in = S_SCAN_EVAL;
         S_SCAN_EVAL: begin
            if (scan_found) begin
               first_in = scan_end - PAGE_W'(cnt_ff) + PAGE_W'(1);
               page_in  = scan_end - PAGE_W'(cnt_ff) + PAGE_W'(1);
               left_in  = cnt_ff;
               state_in = S_PG_RD;
            end else if (byte_ff == zl_ff[PAGE_W-1:3]) begin
               status_in = STATUS_NO_RUN;
               state_in  = S_RESP;
            end else begin
               byte_in  = byte_ff + BYTE_W'(1);
               run_in   = scan_run;
               state_in = S_SCAN_RD;
            end
         end
         S_PG_RD: state_in = S_PG_WR;
         S_PG_WR: begin
            // Saturating zone counters.
            if (upd.in_use_inc && in_use_ff != IN_USE_MAX) begin
               in_use_in = in_use_ff + FREE_W'(1);
            end else if (upd.in_use_dec && in_use_ff != '0) begin
               in_use_in = in_use_ff - FREE_W'(1);
            end
            if (upd.links_inc && links_ff != LINKS_MAX) begin
               links_in = links_ff + LINKS_W'(1);
            end else if (upd.links_dec && links_ff != '0) begin
               links_in = links_ff - LINKS_W'(1);
            end
            left_in = left_ff - COUNT_W'(1);
            page_in = page_ff + PAGE_W'(1);
            state_in = last_page ? S_RESP : S_PG_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = first_ff;
               rsp_free_in   = free_now;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         zf_ff        <= '0;
         zl_ff        <= PAGE_W'(NUM_PAGES - 1);
         in_use_ff    <= '0;
         links_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         zf_ff        <= zf_in;
         zl_ff        <= zl_in;
         in_use_ff    <= in_use_in;
         links_ff     <= links_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      flags_ff      <= flags_in;
      status_ff     <= status_in;
      first_ff      <= first_in;
      page_ff       <= page_in;
      left_ff       <= left_in;
      byte_ff       <= byte_in;
      run_ff        <= run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // A page write always follows its read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PG_WR) |-> ($past(state_ff) == S_PG_RD))
      else $error("page write without a preceding read");

   // A new result appears only out of the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result raised outside the result state");

   // No item is taken during the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("item accepted during clearing pass");

   // Page update steps always have pages left.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PG_RD || state_ff == S_PG_WR) |-> (left_ff != '0))
      else $error("page update with no pages left");

endmodule

`default_nettype wire

/* verif/bpa_alloc_checker.sv */
// Checker that tracks allocator state from the channels and compares every result item.
`timescale 1ns / 1ps

module bpa_alloc_checker import bpa_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   bpa_req_if         req,
   bpa_rsp_if         rsp,
   bpa_csr_if         csr,
   output int         req_count,
   output int         csr_count,
   output int         pending,
   output int         fail_count,
   output int         runs_granted
);

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] first_page;
      logic [FREE_W-1:0] free_pages;
   } page_result_type;

   // Shadow copy of the zone registers and page store.
   logic [PAGE_W-1:0]  zone_lo_q;
   logic [PAGE_W-1:0]  zone_hi_q;
   logic               used_q  [NUM_PAGES];
   logic [FLAGS_W-1:0] attr_q  [NUM_PAGES];
   logic [REFS_W-1:0]  refs_q  [NUM_PAGES];
   logic [FREE_W-1:0]  in_use_q;
   logic [LINKS_W-1:0] links_q;
   page_result_type    result_q[$];

   function automatic logic [FREE_W-1:0] zone_free();
      int size;
      if (zone_lo_q > zone_hi_q) return '0;
      size = int'(zone_hi_q) - int'(zone_lo_q) + 1;
      return (int'(in_use_q) >= size) ? '0 : FREE_W'(size - int'(in_use_q));
   endfunction

   // Page-init rule for one page.
   function automatic void take_one(int p, logic [FLAGS_W-1:0] flags);
      if (attr_q[p] == '0) begin
         used_q[p] = 1'b1;
         attr_q[p] = flags;
         if (refs_q[p] != REFS_MAX) refs_q[p]++;
         if (in_use_q != IN_USE_MAX) in_use_q++;
         if (links_q != LINKS_MAX) links_q++;
      end else if (((attr_q[p] | flags) & MARK_MASK) != '0) begin
         attr_q[p] = attr_q[p] | flags;
         if (refs_q[p] != REFS_MAX) refs_q[p]++;
         if (links_q != LINKS_MAX) links_q++;
      end else begin
         used_q[p] = 1'b1;
         attr_q[p] = attr_q[p] | flags;
      end
   endfunction

   // Page-clean rule for one page.
   function automatic void release_one(int p);
      if (attr_q[p] == '0) return;
      if ((attr_q[p] & MARK_MASK) != '0) begin
         if (refs_q[p] != '0) refs_q[p]--;
         if (links_q != '0) links_q--;
         if (refs_q[p] == '0) begin
            attr_q[p] = '0;
            if (in_use_q != '0) in_use_q--;
         end
      end else begin
         used_q[p] = 1'b0;
         attr_q[p] = '0;
         refs_q[p] = '0;
         if (in_use_q != '0) in_use_q--;
         if (links_q != '0) links_q--;
      end
   endfunction

   function automatic page_result_type apply_command(logic [1:0] cmd, logic [PAGE_W-1:0] idx,
                                                     logic [COUNT_W-1:0] count,
                                                     logic [FLAGS_W-1:0] flags);
      page_result_type r;
      int run;
      int s;
      logic has_zone;
      has_zone = (zone_lo_q <= zone_hi_q);
      r.status = STATUS_OK;
      r.first_page = idx;
      if (cmd == CMD_ALLOC) begin
         r.first_page = '0;
         r.status = STATUS_NO_RUN;
         run = 0;
         if (has_zone && count >= 1 && count <= MAX_RUN && zone_free() >= count) begin
            for (int p = zone_lo_q; p <= zone_hi_q; p++) begin
               run = used_q[p] ? 0 : run + 1;
               if (run == count) begin
                  s = p + 1 - count;
                  for (int k = 0; k < count; k++) take_one(s + k, flags);
                  r.first_page = PAGE_W'(s);
                  r.status = STATUS_OK;
                  break;
               end
            end
         end
      end else if (cmd == CMD_TAKE || cmd == CMD_RELEASE) begin
         if (!has_zone || idx < zone_lo_q || idx > zone_hi_q) r.status = STATUS_OUT_ZONE;
         else if (cmd == CMD_TAKE) take_one(idx, flags);
         else release_one(idx);
      end
      r.free_pages = zone_free();
      return r;
   endfunction

   assign pending = result_q.size();

   always @(posedge clock) begin
      page_result_type want;
      page_result_type got;
      if (reset) begin
         zone_lo_q <= '0;
         zone_hi_q <= '1;
         in_use_q = '0;
         links_q = '0;
         for (int p = 0; p < NUM_PAGES; p++) begin
            used_q[p] = 1'b0;
            attr_q[p] = '0;
            refs_q[p] = '0;
         end
         result_q.delete();
         req_count <= 0;
         csr_count <= 0;
         fail_count <= 0;
         runs_granted <= 0;
      end else begin
         // Compare a delivered result with the oldest prediction.
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.status, rsp.first_page, rsp.free_pages};
            if (result_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result status=%0d first=%0d free=%0d",
                           $realtime, got.status, got.first_page, got.free_pages);
               fail_count <= fail_count + 1;
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: result mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                              $realtime, want.status, want.first_page, want.free_pages,
                              got.status, got.first_page, got.free_pages);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Predict the result of each accepted item.
         if (req.valid && req.ready) begin
            want = apply_command(req.cmd, req.page_index, req.page_count, req.attr_flags);
            if (req.cmd == CMD_ALLOC && want.status == STATUS_OK)
               runs_granted <= runs_granted + 1;
            result_q.push_back(want);
            req_count <= req_count + 1;
         end
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_ZONE_FIRST) zone_lo_q <= csr.data;
            else if (csr.index == CSR_ZONE_LAST) zone_hi_q <= csr.data;
            csr_count <= csr_count + 1;
         end
      end
   end

endmodule

/* verif/tb.sv */
// Testbench top: clock, reset, stimulus phases and verdict for the page allocator.
`timescale 1ns / 1ps

module tb;
   import bpa_pkg::*;

   logic clock;
   logic reset;
   int   req_count, csr_count, pending, fail_count, runs_granted;
   int   send_idle_pct, recv_stall_pct;
   int   hold_asked, hold_served, hold_left;
   int   sent_by_cmd[4];
   logic [PAGE_W-1:0] zone_lo, zone_hi;

   bpa_req_if req_chan();
   bpa_rsp_if rsp_chan();
   bpa_csr_if csr_chan();

   bitmap_page_allocator dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   bpa_alloc_checker checker_i (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan), .csr(csr_chan),
      .req_count(req_count), .csr_count(csr_count), .pending(pending),
      .fail_count(fail_count), .runs_granted(runs_granted)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net against a hung block.
   initial begin
      #40ms;
      $display("bitmap_page_allocator regression: fail");
      $finish;
   end

   // Result side: random stalls, plus long hold-offs when asked.
   initial begin
      rsp_chan.ready = 1'b0;
      hold_served = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [PAGE_W-1:0] idx,
                            logic [COUNT_W-1:0] count, logic [FLAGS_W-1:0] flags);
      int seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.cmd = cmd;
      req_chan.page_index = idx;
      req_chan.page_count = count;
      req_chan.attr_flags = flags;
      req_chan.valid = 1'b1;
      seen = req_count;
      do @(negedge clock); while (req_count == seen);
      sent_by_cmd[cmd]++;
   endtask

   // Drain all results, then write both zone registers.
   task automatic set_zone(logic [PAGE_W-1:0] lo, logic [PAGE_W-1:0] hi);
      int seen;
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_chan.index = CSR_ZONE_FIRST;
      csr_chan.data = lo;
      csr_chan.valid = 1'b1;
      seen = csr_count;
      do @(negedge clock); while (csr_count == seen);
      csr_chan.index = CSR_ZONE_LAST;
      csr_chan.data = hi;
      seen = csr_count;
      do @(negedge clock); while (csr_count == seen);
      csr_chan.valid = 1'b0;
      zone_lo = lo;
      zone_hi = hi;
   endtask

   function automatic logic [FLAGS_W-1:0] pick_flags();
      case ($urandom_range(3))
         0: return '0;
         1: return FLAGS_W'($urandom_range(1) ? (1 << REF_BIT) : (1 << SHARE_BIT));
         2: return FLAGS_W'($urandom) & ~MARK_MASK;
         default: return FLAGS_W'($urandom);
      endcase
   endfunction

   // Mostly commands aimed at the zone, with a few out-of-zone and malformed items.
   task automatic random_items(int n);
      int w;
      logic [PAGE_W-1:0] idx;
      logic [COUNT_W-1:0] count;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(99);
         if (zone_lo <= zone_hi && $urandom_range(9) != 0)
            idx = PAGE_W'($urandom_range(zone_hi, zone_lo));
         else
            idx = PAGE_W'($urandom);
         if ($urandom_range(19) == 0) count = COUNT_W'($urandom);
         else if ($urandom_range(9) == 0) count = COUNT_W'(MAX_RUN);
         else count = COUNT_W'($urandom_range(8, 1));
         if (w < 30) send_item(CMD_ALLOC, idx, count, pick_flags());
         else if (w < 62) send_item(CMD_TAKE, idx, count, pick_flags());
         else if (w < 97) send_item(CMD_RELEASE, idx, count, pick_flags());
         else send_item(CMD_NONE, idx, count, pick_flags());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_NONE;
      req_chan.page_index = '0;
      req_chan.page_count = '0;
      req_chan.attr_flags = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_ZONE_FIRST;
      csr_chan.data = '0;
      hold_asked = 0;
      send_idle_pct = 10;
      recv_stall_pct = 47;
      zone_lo = '0;
      zone_hi = '1;
      foreach (sent_by_cmd[c]) sent_by_cmd[c] = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: run lengths at the limits, take and release rules, unknown command.
      send_item(CMD_ALLOC, '0, 7'd1, 16'hFFFF);
      send_item(CMD_ALLOC, '0, 7'(MAX_RUN), 16'h0001);
      send_item(CMD_ALLOC, '0, 7'd0, 16'h0002);
      send_item(CMD_ALLOC, '0, 7'(MAX_RUN + 1), 16'h0002);
      send_item(CMD_ALLOC, '0, 7'h7F, 16'h0002);
      send_item(CMD_TAKE, 10'd1023, 7'd0, 16'h0000);
      send_item(CMD_TAKE, 10'd1023, 7'd0, 16'h0001);
      send_item(CMD_TAKE, 10'd1023, 7'd0, 16'h0002);
      send_item(CMD_RELEASE, 10'd1023, 7'd0, 16'h0000);
      send_item(CMD_RELEASE, 10'd1023, 7'd0, 16'h0000);
      send_item(CMD_TAKE, 10'd900, 7'd0, 16'(1 << REF_BIT));
      send_item(CMD_TAKE, 10'd900, 7'd0, 16'(1 << SHARE_BIT));
      send_item(CMD_TAKE, 10'd900, 7'd0, 16'h0000);
      send_item(CMD_RELEASE, 10'd900, 7'd0, 16'h0000);
      send_item(CMD_RELEASE, 10'd900, 7'd0, 16'h0000);
      send_item(CMD_RELEASE, 10'd900, 7'd0, 16'h0000);
      send_item(CMD_TAKE, 10'd1, 7'd0, 16'h0004);
      send_item(CMD_NONE, 10'h2AA, 7'h55, 16'hA5A5);

      // Directed: small zone with pages just outside it, then an empty zone.
      set_zone(10'd100, 10'd163);
      send_item(CMD_TAKE, 10'd99, 7'd0, 16'h0001);
      send_item(CMD_RELEASE, 10'd164, 7'd0, 16'h0000);
      send_item(CMD_ALLOC, '0, 7'(MAX_RUN), 16'h0010);
      send_item(CMD_ALLOC, '0, 7'd1, 16'h0010);
      send_item(CMD_RELEASE, 10'd130, 7'd0, 16'h0000);
      set_zone(10'd500, 10'd400);
      send_item(CMD_ALLOC, '0, 7'd1, 16'h0001);
      send_item(CMD_TAKE, 10'd450, 7'd0, 16'h0001);

      // Random: sender idles lightly, receiver stalls often.
      set_zone(10'd0, 10'd1023);
      random_items(220);
      set_zone(10'd960, 10'd1023);
      random_items(150);

      // Random: sender idles often, receiver stalls lightly.
      send_idle_pct = 47;
      recv_stall_pct = 10;
      set_zone(10'd1023, 10'd1023);
      random_items(30);
      set_zone(10'd512, 10'd527);
      random_items(120);

      // Random: no idling, with one long receiver hold-off to back up the block.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_zone(10'd0, 10'd1023);
      hold_asked++;
      random_items(200);
      set_zone(10'd0, 10'd0);
      random_items(30);
      set_zone(10'd37, 10'd101);
      random_items(80);

      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("Sent %0d alloc, %0d take, %0d release, %0d unknown items; %0d runs granted.",
               sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3], runs_granted);
      $display("Zone writes: %0d; mismatches: %0d.", csr_count, fail_count);
      if (fail_count == 0) begin
         $display("bitmap_page_allocator regression: pass");
      end else begin
         $display("bitmap_page_allocator regression: fail");
      end
      $finish;
   end

endmodule

/* bitmap_page_allocator.f */
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_page_rule.sv
rtl/core/bitmap_page_allocator.sv
verif/bpa_alloc_checker.sv
verif/tb.sv
